@@ src/pgn_pkg.sv @@
`timescale 1ns / 1ps

package pgn_pkg;

    // width of the uniform fractions as they arrive
    localparam int UNIFORM_BITS = 32;

    localparam int ALIGN_LSH = (UNIFORM_BITS < 32) ? 32 - UNIFORM_BITS : 0;
    localparam int ALIGN_RSH = (UNIFORM_BITS > 32) ? UNIFORM_BITS - 32 : 0;
    localparam logic [31:0] ALIGN_MASK = (UNIFORM_BITS >= 32) ? 32'hFFFF_FFFF
                                       : 32'((64'd1 << UNIFORM_BITS) - 64'd1);

    localparam logic [31:0] HALF    = 32'h8000_0000;
    localparam logic [23:0] LN2_Q24 = 24'hB17218;

    // depth of the queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    typedef struct packed {
        logic [31:0] uniform_a;
        logic [31:0] uniform_b;
    } pgn_in_t;

    typedef struct packed {
        logic signed [31:0] normal_sample;
        logic               last;
    } pgn_out_t;

    // signs and magnitudes of v1 and v2
    typedef struct packed {
        logic        n1;
        logic        n2;
        logic [30:0] mag1;
        logic [30:0] mag2;
    } pgn_side_t;

    // queue item: an accepted pair with its exact radius squared
    typedef struct packed {
        pgn_side_t   side;
        logic [61:0] rsq;
    } pgn_mid_t;

    // products handed from the back pipeline to the result stage
    typedef struct packed {
        logic        n1;
        logic        n2;
        logic [63:0] p1;
        logic [63:0] p2;
    } pgn_prod_t;

    function automatic logic [31:0] align_uniform(logic [31:0] raw);
        logic [31:0] u;
        u = (raw & ALIGN_MASK) << ALIGN_LSH;
        u = u >> ALIGN_RSH;
        return u;
    endfunction

endpackage

@@ src/pgn_front.sv @@
`timescale 1ns / 1ps

module pgn_front
    import pgn_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     src_valid,
    output logic     src_stall,
    input  pgn_in_t  src_data,
    input  logic     q_full,
    output logic     q_push,
    output pgn_mid_t q_data
);

    logic        s1_valid_reg;
    logic        s1_n1_reg, s1_n2_reg;
    logic [31:0] s1_mag1_reg, s1_mag2_reg;

    logic        s2_valid_reg;
    logic        s2_n1_reg, s2_n2_reg;
    logic [31:0] s2_mag1_reg, s2_mag2_reg;
    logic [63:0] s2_sq1_reg, s2_sq2_reg;

    logic [31:0] u1, u2;
    logic        n1, n2;
    logic [63:0] rsq;
    logic        keep;
    logic        f_en;

    always_comb
    begin
        u1 = align_uniform(src_data.uniform_a);
        u2 = align_uniform(src_data.uniform_b);
        n1 = u1 < HALF;
        n2 = u2 < HALF;
    end

    // rejection: radius zero, or on or outside the unit circle
    assign rsq    = s2_sq1_reg + s2_sq2_reg;
    assign keep   = (rsq != 64'd0) && (rsq[63:62] == 2'b00);
    assign f_en   = !(s2_valid_reg && keep && q_full);
    assign q_push = s2_valid_reg && keep && !q_full;

    assign src_stall = !f_en;

    assign q_data.side.n1   = s2_n1_reg;
    assign q_data.side.n2   = s2_n2_reg;
    assign q_data.side.mag1 = s2_mag1_reg[30:0];
    assign q_data.side.mag2 = s2_mag2_reg[30:0];
    assign q_data.rsq       = rsq[61:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (f_en)
        begin
            s1_valid_reg <= src_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (f_en)
        begin
            s1_n1_reg   <= n1;
            s1_n2_reg   <= n2;
            s1_mag1_reg <= n1 ? HALF - u1 : u1 - HALF;
            s1_mag2_reg <= n2 ? HALF - u2 : u2 - HALF;
            s2_n1_reg   <= s1_n1_reg;
            s2_n2_reg   <= s1_n2_reg;
            s2_mag1_reg <= s1_mag1_reg;
            s2_mag2_reg <= s1_mag2_reg;
            s2_sq1_reg  <= 64'(s1_mag1_reg) * 64'(s1_mag1_reg);
            s2_sq2_reg  <= 64'(s1_mag2_reg) * 64'(s1_mag2_reg);
        end
    end

endmodule

@@ src/pgn_queue.sv @@
`timescale 1ns / 1ps

module pgn_queue
    import pgn_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  pgn_mid_t push_data,
    output logic     full,
    input  logic     pop,
    output logic     nonempty,
    output pgn_mid_t head
);

    pgn_mid_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]       count_reg;

    assign full     = count_reg == (QPTR_W+1)'(QDEPTH);
    assign nonempty = count_reg != '0;
    assign head     = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

@@ src/pgn_back.sv @@
`timescale 1ns / 1ps

module pgn_back
    import pgn_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_nonempty,
    input  pgn_mid_t  q_head,
    output logic      q_pop,
    output logic      p_valid,
    output pgn_prod_t p_data,
    input  logic      p_ready
);

    localparam int NRM_STEPS = 6;
    localparam int LOG_STEPS = 31;
    localparam int SQ_STEPS  = 32;

    typedef struct packed {
        pgn_side_t   side;
        logic [62:0] m;
        logic [5:0]  k;
    } nrm_t;

    typedef struct packed {
        pgn_side_t   side;
        logic [31:0] x;
        logic [30:0] f;
        logic [5:0]  k;
        logic [4:0]  j;
        logic [61:0] nr;
        logic [35:0] rem;
        logic [30:0] root;
    } lr_t;

    typedef struct packed {
        logic        n1;
        logic        n2;
        logic [63:0] t2;
        logic [35:0] srem;
        logic [31:0] sroot;
        logic [30:0] root;
        logic [31:0] dr1;
        logic [31:0] dr2;
        logic [31:0] dd1;
        logic [31:0] dd2;
        logic [31:0] q1;
        logic [31:0] q2;
    } sd_t;

    logic      nrm_v_reg [NRM_STEPS];
    nrm_t      nrm_reg   [NRM_STEPS];
    logic      lr_v_reg  [LOG_STEPS];
    lr_t       lr_reg    [LOG_STEPS];
    logic      t_v_reg;
    sd_t       t_reg;
    logic      sd_v_reg  [SQ_STEPS];
    sd_t       sd_reg    [SQ_STEPS];
    logic      p_v_reg;
    pgn_prod_t p_reg;

    logic b_en;

    // leading-zero removal, one power-of-two shift a stage
    function automatic nrm_t nrm_step(nrm_t a, int unsigned sh);
        nrm_t r;
        r = a;
        if ((a.m >> (63 - sh)) == 63'd0)
        begin
            r.m = a.m << sh;
            r.k = a.k + 6'(sh);
        end
        return r;
    endfunction

    function automatic lr_t lr_init(nrm_t n);
        lr_t         r;
        logic [5:0]  km1;
        km1    = n.k - 6'd1;
        r.side = n.side;
        r.x    = n.m[62:31];
        r.f    = '0;
        r.k    = n.k;
        r.j    = km1[5:1];
        r.nr   = n.k[0] ? n.m[62:1] : {1'b0, n.m[62:2]};
        r.rem  = '0;
        r.root = '0;
        return r;
    endfunction

    // one squaring round of the log and one digit of the radius root
    function automatic lr_t lr_step(lr_t a);
        lr_t         r;
        logic [63:0] p;
        logic [32:0] xs;
        logic [35:0] rem2;
        logic [35:0] trial;
        logic        ge;
        r  = a;
        p  = 64'(a.x) * 64'(a.x);
        xs = p[63:31];
        if (xs[32])
        begin
            r.f = {a.f[29:0], 1'b1};
            r.x = xs[32:1];
        end
        else
        begin
            r.f = {a.f[29:0], 1'b0};
            r.x = xs[31:0];
        end
        rem2   = {a.rem[33:0], a.nr[61:60]};
        trial  = {3'b000, a.root, 2'b01};
        ge     = rem2 >= trial;
        r.rem  = ge ? rem2 - trial : rem2;
        r.root = {a.root[29:0], ge};
        r.nr   = {a.nr[59:0], 2'b00};
        return r;
    endfunction

    function automatic sd_t t_init(lr_t l);
        sd_t         r;
        logic [36:0] lq;
        logic [60:0] prod;
        logic [60:0] a1, a2;
        lq      = {l.k, 31'd0} - {6'd0, l.f};
        prod    = 61'(lq) * 61'(LN2_Q24);
        a1      = 61'(l.side.mag1) << l.j;
        a2      = 61'(l.side.mag2) << l.j;
        r.n1    = l.side.n1;
        r.n2    = l.side.n2;
        r.t2    = {1'b0, prod, 2'b00};
        r.srem  = '0;
        r.sroot = '0;
        r.root  = l.root;
        r.dr1   = a1[32:1];
        r.dr2   = a2[32:1];
        r.dd1   = {a1[0], 31'd0};
        r.dd2   = {a2[0], 31'd0};
        r.q1    = '0;
        r.q2    = '0;
        return r;
    endfunction

    // restoring divide step: returns quotient bit and new remainder
    function automatic logic [32:0] div_step(logic [31:0] dr, logic b, logic [30:0] root);
        logic [32:0] rem2;
        logic        ge;
        rem2 = {dr, b};
        ge   = rem2 >= {2'b00, root};
        rem2 = ge ? rem2 - {2'b00, root} : rem2;
        return {ge, rem2[31:0]};
    endfunction

    function automatic sd_t sd_step(sd_t a);
        sd_t         r;
        logic [35:0] rem2;
        logic [35:0] trial;
        logic        ge;
        logic [32:0] d1, d2;
        r       = a;
        rem2    = {a.srem[33:0], a.t2[63:62]};
        trial   = {2'b00, a.sroot, 2'b01};
        ge      = rem2 >= trial;
        r.srem  = ge ? rem2 - trial : rem2;
        r.sroot = {a.sroot[30:0], ge};
        r.t2    = {a.t2[61:0], 2'b00};
        d1      = div_step(a.dr1, a.dd1[31], a.root);
        d2      = div_step(a.dr2, a.dd2[31], a.root);
        r.dr1   = d1[31:0];
        r.dr2   = d2[31:0];
        r.q1    = {a.q1[30:0], d1[32]};
        r.q2    = {a.q2[30:0], d2[32]};
        r.dd1   = {a.dd1[30:0], 1'b0};
        r.dd2   = {a.dd2[30:0], 1'b0};
        return r;
    endfunction

    // whole pipeline holds when the result stage cannot take its item
    assign b_en    = !p_v_reg || p_ready;
    assign q_pop   = q_nonempty && b_en;
    assign p_valid = p_v_reg;
    assign p_data  = p_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NRM_STEPS; i++)
                nrm_v_reg[i] <= 1'b0;
            for (int i = 0; i < LOG_STEPS; i++)
                lr_v_reg[i] <= 1'b0;
            t_v_reg <= 1'b0;
            for (int i = 0; i < SQ_STEPS; i++)
                sd_v_reg[i] <= 1'b0;
            p_v_reg <= 1'b0;
        end
        else if (b_en)
        begin
            nrm_v_reg[0] <= q_nonempty;
            for (int i = 1; i < NRM_STEPS; i++)
                nrm_v_reg[i] <= nrm_v_reg[i-1];
            lr_v_reg[0] <= nrm_v_reg[NRM_STEPS-1];
            for (int i = 1; i < LOG_STEPS; i++)
                lr_v_reg[i] <= lr_v_reg[i-1];
            t_v_reg <= lr_v_reg[LOG_STEPS-1];
            sd_v_reg[0] <= t_v_reg;
            for (int i = 1; i < SQ_STEPS; i++)
                sd_v_reg[i] <= sd_v_reg[i-1];
            p_v_reg <= sd_v_reg[SQ_STEPS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_en)
        begin
            nrm_reg[0] <= nrm_step('{side: q_head.side, m: {1'b0, q_head.rsq}, k: 6'd0}, 32);
            for (int i = 1; i < NRM_STEPS; i++)
                nrm_reg[i] <= nrm_step(nrm_reg[i-1], 32 >> i);
            lr_reg[0] <= lr_step(lr_init(nrm_reg[NRM_STEPS-1]));
            for (int i = 1; i < LOG_STEPS; i++)
                lr_reg[i] <= lr_step(lr_reg[i-1]);
            t_reg <= t_init(lr_reg[LOG_STEPS-1]);
            sd_reg[0] <= sd_step(t_reg);
            for (int i = 1; i < SQ_STEPS; i++)
                sd_reg[i] <= sd_step(sd_reg[i-1]);
            p_reg.n1 <= sd_reg[SQ_STEPS-1].n1;
            p_reg.n2 <= sd_reg[SQ_STEPS-1].n2;
            p_reg.p1 <= 64'(sd_reg[SQ_STEPS-1].q1) * 64'(sd_reg[SQ_STEPS-1].sroot);
            p_reg.p2 <= 64'(sd_reg[SQ_STEPS-1].q2) * 64'(sd_reg[SQ_STEPS-1].sroot);
        end
    end

endmodule

@@ src/pgn_out.sv @@
`timescale 1ns / 1ps

module pgn_out
    import pgn_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      p_valid,
    input  pgn_prod_t p_data,
    output logic      p_ready,
    output logic      dst_valid,
    input  logic      dst_stall,
    output pgn_out_t  dst_data
);

    logic        hold_valid_reg;
    logic        phase_reg;
    logic [31:0] first_reg, second_reg;
    logic        load;
    logic        take;

    // round half away from zero, then sign and clamp to Q5.27
    function automatic logic [31:0] to_sample(logic [63:0] p, logic neg);
        logic [64:0] sum;
        logic [32:0] m;
        logic [32:0] mc;
        sum = {1'b0, p} + 65'(HALF);
        m   = sum[64:32];
        if (neg)
        begin
            mc = (m > 33'h0_8000_0000) ? 33'h0_8000_0000 : m;
            return ~mc[31:0] + 32'd1;
        end
        return (m > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
    endfunction

    assign take      = hold_valid_reg && !dst_stall;
    assign p_ready   = !hold_valid_reg || (phase_reg && !dst_stall);
    assign load      = p_valid && p_ready;
    assign dst_valid = hold_valid_reg;

    assign dst_data.normal_sample = phase_reg ? second_reg : first_reg;
    assign dst_data.last          = phase_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            phase_reg      <= 1'b0;
        end
        else if (load)
        begin
            hold_valid_reg <= 1'b1;
            phase_reg      <= 1'b0;
        end
        else if (take)
        begin
            if (phase_reg)
                hold_valid_reg <= 1'b0;
            phase_reg <= !phase_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            first_reg  <= to_sample(p_data.p2, p_data.n2);
            second_reg <= to_sample(p_data.p1, p_data.n1);
        end
    end

endmodule

@@ src/polar_gaussian_noise_unit.sv @@
`timescale 1ns / 1ps

// marsaglia polar gaussian generator in fixed point: each input item is a pair
// of uniform fractions; a pair inside the unit circle (and not at its center)
// gives two result items in signed Q5.27, v2*fac first and v1*fac second with
// last set, while any other pair gives nothing. a new item can be accepted
// every cycle while src_stall is low; each kept pair holds the result port until
// both of its samples are sent, while a rejected pair never reaches it.
// from acceptance to the first result an item passes through 2 front
// stages, the queue, 6 normalize stages, 31 log-squaring stages (run beside
// the radius square root), 1 scaling multiply, 32 digit stages (square root of
// the log term beside both divides), 1 product stage and the result register.

module polar_gaussian_noise_unit
    import pgn_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     src_valid,
    output logic     src_stall,
    input  pgn_in_t  src_data,
    output logic     dst_valid,
    input  logic     dst_stall,
    output pgn_out_t dst_data
);

    // front to queue
    logic      q_push;
    logic      q_full;
    pgn_mid_t  q_wdata;

    // queue to back
    logic      q_pop;
    logic      q_nonempty;
    pgn_mid_t  q_head;

    // back to result stage
    logic      p_valid;
    logic      p_ready;
    pgn_prod_t p_data;

    // front: align, square, reject pairs outside the unit circle
    pgn_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_data  (src_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_wdata)
    );

    // short queue so front and back stall on their own
    pgn_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .nonempty  (q_nonempty),
        .head      (q_head)
    );

    // back: log, square roots, divides and final products
    pgn_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_nonempty (q_nonempty),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .p_valid    (p_valid),
        .p_data     (p_data),
        .p_ready    (p_ready)
    );

    // result stage: round, saturate and send the two samples in turn
    pgn_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .p_valid   (p_valid),
        .p_data    (p_data),
        .p_ready   (p_ready),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .dst_data  (dst_data)
    );

endmodule
